// ===== sv/bfsu_pkg.sv =====
// bfsu_pkg: shared types and constants of the boid flock steering block.
// Used by bfsu_alu and boid_flock_steering_update_top; depends on nothing.
package bfsu_pkg;

  localparam int FRAC_BITS   = 8;
  localparam longint ONE_RAW = longint'(1) << FRAC_BITS;
  localparam longint RADIUS_RAW = ONE_RAW * 40;
  localparam logic [49:0] RADIUS_SQ = 50'(RADIUS_RAW * RADIUS_RAW);
  localparam logic [16:0] SEEK_SCALE  = 17'((ONE_RAW * 5) / 4);
  localparam logic [16:0] ALIGN_SCALE = 17'((ONE_RAW * 6) / 5);
  localparam logic [16:0] SEP_SCALE   = 17'(ONE_RAW * 200);

  localparam logic [9:0] SPAWN_RESET = 10'd32;

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  localparam int DIV_STEPS  = 42;
  localparam int SQRT_STEPS = 25;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_t;

  // mul: a[27:0] * b, both signed. div: a[41:0] signed / b unsigned.
  // sqrt: floor root of a unsigned.
  typedef struct packed {
    logic        start;
    alu_op_t     op;
    logic [49:0] a;
    logic [27:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [55:0] res;
  } alu_rsp_t;

  typedef struct packed {
    logic [15:0]        id;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
  } entry_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [15:0]        boid_id;
    logic signed [23:0] start_x;
    logic signed [23:0] start_y;
    logic signed [23:0] target_x;
    logic signed [23:0] target_y;
    logic [15:0]        time_step;
  } req_t;

  typedef struct packed {
    logic [15:0]        out_id;
    logic signed [23:0] out_pos_x;
    logic signed [23:0] out_pos_y;
    logic signed [23:0] out_vel_x;
    logic signed [23:0] out_vel_y;
    logic               accepted;
    logic               last;
  } rsp_t;

endpackage

// ===== sv/bfsu_ram.sv =====
// bfsu_ram: generic single write port RAM with registered read.
// No dependencies.
module bfsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/bfsu_alu.sv =====
// bfsu_alu: shared arithmetic unit: registered multiplier, bit-serial divider
// and square root sharing one remainder register and subtractor. Uses bfsu_pkg.
module bfsu_alu (
  input  logic               clk,
  input  logic               rst,
  input  bfsu_pkg::alu_req_t req,
  output bfsu_pkg::alu_rsp_t rsp
);

  logic                busy;
  logic                done;
  bfsu_pkg::alu_op_t   op_r;
  logic [5:0]          cnt;
  logic [28:0]         rem;
  logic [49:0]         shreg;
  logic [41:0]         quo;
  logic [27:0]         divisor;
  logic                neg;
  logic signed [55:0]  prod;

  logic [28:0] rem_sh;
  logic [28:0] sub_s;
  logic [29:0] diff;
  logic        ge;
  logic [41:0] mag;
  logic [41:0] qs;

  assign mag = req.a[41] ? (42'd0 - req.a[41:0]) : req.a[41:0];
  assign qs  = neg ? (42'd0 - quo) : quo;

  always_comb begin
    if (op_r == bfsu_pkg::ALU_SQRT) begin
      rem_sh = {rem[26:0], shreg[49:48]};
      sub_s  = {2'b00, quo[24:0], 2'b01};
    end else begin
      rem_sh = {rem[27:0], shreg[41]};
      sub_s  = {1'b0, divisor};
    end
    diff = {1'b0, rem_sh} - {1'b0, sub_s};
    ge   = !diff[29];
  end

  always_comb begin
    rsp.done = done;
    case (op_r)
      bfsu_pkg::ALU_MUL:  rsp.res = prod;
      bfsu_pkg::ALU_DIV:  rsp.res = {{14{qs[41]}}, qs};
      bfsu_pkg::ALU_SQRT: rsp.res = {31'd0, quo[24:0]};
      default:            rsp.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      op_r <= bfsu_pkg::ALU_MUL;
    end else begin
      done <= 1'b0;
      if (busy) begin
        rem   <= ge ? diff[28:0] : rem_sh;
        quo   <= {quo[40:0], ge};
        shreg <= (op_r == bfsu_pkg::ALU_SQRT) ? (shreg << 2) : (shreg << 1);
        cnt   <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (req.start) begin
        op_r <= req.op;
        case (req.op)
          bfsu_pkg::ALU_MUL: begin
            prod <= $signed(req.a[27:0]) * $signed(req.b);
            done <= 1'b1;
          end
          bfsu_pkg::ALU_DIV: begin
            neg     <= req.a[41];
            shreg   <= {8'd0, mag};
            rem     <= '0;
            quo     <= '0;
            divisor <= req.b;
            cnt     <= 6'(bfsu_pkg::DIV_STEPS);
            busy    <= 1'b1;
          end
          bfsu_pkg::ALU_SQRT: begin
            shreg <= req.a;
            rem   <= '0;
            quo   <= '0;
            cnt   <= 6'(bfsu_pkg::SQRT_STEPS);
            busy  <= 1'b1;
          end
          default: begin
            done <= 1'b1;
          end
        endcase
      end
    end
  end

endmodule

// ===== sv/boid_flock_steering_update_top.sv =====
// boid_flock_steering_update_top: boid table, sequencer and result register.
// Depends on bfsu_pkg, bfsu_ram and bfsu_alu.
//
//  channel  signals                         payload
//  req      req_valid / req_stall           bfsu_pkg::req_t
//  rsp      rsp_valid / rsp_stall           bfsu_pkg::rsp_t
//  cfg      cfg_write                       cfg_data (max_spawns)
//
// Add writes one table entry, remove scans and compacts the table, a tick visits
// every boid pair, its run time set by the ALU's bit-serial divide and root.
// req_stall is high from a transfer until the item's last result is loaded.
// A held result waits in the output register; work pauses only on the next one.
// Synchronous reset empties the table and sets max_spawns to 32.
module boid_flock_steering_update_top #(
  parameter int MAX_BOIDS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  bfsu_pkg::req_t   req_data,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output bfsu_pkg::rsp_t   rsp_data,
  input  logic             cfg_write,
  input  logic [9:0]       cfg_data
);

  localparam int CW     = $clog2(MAX_BOIDS + 1);
  localparam int IW     = $clog2(MAX_BOIDS);
  localparam int SUMV_W = 24 + CW;
  localparam int SEP_W  = 18 + CW;

  typedef enum logic [5:0] {
    S_IDLE, S_ADD, S_RM_RD, S_RM_WR, S_OWN, S_OWN2, S_SEEK_DONE,
    S_NB, S_NB1, S_NB2, S_NB3, S_NB4, S_NB5, S_NB6, S_NB7, S_NB8,
    S_ALIGN, S_AL1, S_AL2, S_AL3, S_SEPD, S_SE1, S_SE2, S_SEPC, S_SE3,
    S_INT, S_I1, S_I2, S_I3, S_I4, S_WB, S_EMIT,
    S_NS0, S_NS1, S_NS2, S_NS3, S_NS4, S_NS5, S_NS6, S_NS7
  } state_t;

  function automatic logic signed [39:0] trunc16(input logic signed [55:0] p);
    logic signed [55:0] t;
    t = p + (p[55] ? 56'sd65535 : 56'sd0);
    return 40'(t >>> 16);
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [41:0] v);
    logic signed [23:0] r;
    if (v > 42'sd8388607) r = 24'sh7FFFFF;
    else if (v < -42'sd8388608) r = 24'sh800000;
    else r = 24'(v);
    return r;
  endfunction

  state_t st;
  state_t emit_next;
  state_t ns_ret;

  bfsu_pkg::req_t   rq;
  bfsu_pkg::rsp_t   pend;
  logic [CW-1:0]    live;
  logic [9:0]       add_count;
  logic [9:0]       max_spawns;
  logic [CW-1:0]    i, j, r, w;
  logic             found;

  logic [15:0]        oid;
  logic signed [23:0] opx, opy, ovx, ovy;
  logic signed [24:0] dx, dy;
  logic signed [24:0] nsx, nsy;
  logic [16:0]        nsc;
  logic signed [17:0] nx, ny;
  logic [24:0]        len;
  logic [26:0]        l2;
  logic [49:0]        sq;
  logic signed [26:0] ax, ay;
  logic [CW-1:0]      acnt, scnt;
  logic signed [SUMV_W-1:0] sumvx, sumvy;
  logic signed [SEP_W-1:0]  sepx, sepy;

  bfsu_pkg::alu_req_t alu_req;
  bfsu_pkg::alu_rsp_t alu_rsp;
  logic signed [55:0] prod;
  logic signed [41:0] q;
  logic [24:0]        root;
  logic [49:0]        sum_sq;
  logic signed [23:0] int_base;
  logic signed [23:0] int_sum;

  logic                     ram_we;
  logic [IW-1:0]            ram_waddr;
  bfsu_pkg::entry_t         ram_wdata;
  logic                     ram_re;
  logic [IW-1:0]            ram_raddr;
  logic [$bits(bfsu_pkg::entry_t)-1:0] ram_rdata;
  bfsu_pkg::entry_t         rd_e;
  logic                     add_ok;
  logic                     rsp_free;

  assign rd_e     = bfsu_pkg::entry_t'(ram_rdata);
  assign prod     = $signed(alu_rsp.res);
  assign q        = $signed(alu_rsp.res[41:0]);
  assign root     = alu_rsp.res[24:0];
  assign sum_sq   = sq + prod[49:0];
  assign add_ok   = (live < CW'(MAX_BOIDS)) && (add_count < max_spawns);
  assign rsp_free = !rsp_valid || !rsp_stall;
  assign req_stall = (st != S_IDLE);

  bfsu_ram #(
    .WIDTH ($bits(bfsu_pkg::entry_t)),
    .DEPTH (MAX_BOIDS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bfsu_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // table port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = i[IW-1:0];
    ram_wdata = '{id: oid, px: opx, py: opy, vx: ovx, vy: ovy};
    ram_re    = 1'b0;
    ram_raddr = j[IW-1:0];
    case (st)
      S_ADD: begin
        ram_we    = add_ok;
        ram_waddr = live[IW-1:0];
        ram_wdata = '{id: rq.boid_id, px: rq.start_x, py: rq.start_y,
                      vx: 24'sd0, vy: 24'sd0};
      end
      S_RM_RD: begin
        ram_re    = (r != live);
        ram_raddr = r[IW-1:0];
      end
      S_RM_WR: begin
        ram_we    = (rd_e.id != rq.boid_id);
        ram_waddr = w[IW-1:0];
        ram_wdata = rd_e;
      end
      S_OWN: begin
        ram_re    = 1'b1;
        ram_raddr = i[IW-1:0];
      end
      S_NB: begin
        ram_re = (j != live) && (j != i);
      end
      S_WB: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // operand selection for the shared unit
  always_comb begin
    alu_req       = '0;
    alu_req.op    = bfsu_pkg::ALU_MUL;
    case (st)
      S_NS0: begin
        alu_req.start   = 1'b1;
        alu_req.a[27:0] = 28'(nsx);
        alu_req.b       = 28'(nsx);
      end
      S_NS1: begin
        alu_req.start   = alu_rsp.done;
        alu_req.a[27:0] = 28'(nsy);
        alu_req.b       = 28'(nsy);
      end
      S_NS2: begin
        alu_req.start = alu_rsp.done;
        alu_req.op    = bfsu_pkg::ALU_SQRT;
        alu_req.a     = sum_sq;
      end
      S_NS3: begin
        alu_req.start   = alu_rsp.done && (root != 25'd0);
        alu_req.a[27:0] = 28'(nsx);
        alu_req.b       = 28'(nsc);
      end
      S_NS4, S_NS6: begin
        alu_req.start   = alu_rsp.done;
        alu_req.op      = bfsu_pkg::ALU_DIV;
        alu_req.a[41:0] = prod[41:0];
        alu_req.b       = 28'(len);
      end
      S_NS5: begin
        alu_req.start   = alu_rsp.done;
        alu_req.a[27:0] = 28'(nsy);
        alu_req.b       = 28'(nsc);
      end
      S_NB2: begin
        alu_req.start   = 1'b1;
        alu_req.a[27:0] = 28'(dx);
        alu_req.b       = 28'(dx);
      end
      S_NB3: begin
        alu_req.start   = alu_rsp.done;
        alu_req.a[27:0] = 28'(dy);
        alu_req.b       = 28'(dy);
      end
      S_NB4: begin
        alu_req.start = alu_rsp.done && (sum_sq < bfsu_pkg::RADIUS_SQ);
        alu_req.op    = bfsu_pkg::ALU_SQRT;
        alu_req.a     = sum_sq;
      end
      S_NB5: begin
        alu_req.start   = alu_rsp.done && (root != 25'd0);
        alu_req.a[27:0] = 28'(root);
        alu_req.b       = 28'(root);
      end
      S_NB6: begin
        alu_req.start   = alu_rsp.done;
        alu_req.op      = bfsu_pkg::ALU_DIV;
        alu_req.a[41:0] = {dx[24], dx, 16'd0};
        alu_req.b       = prod[27:0];
      end
      S_NB7: begin
        alu_req.start   = alu_rsp.done;
        alu_req.op      = bfsu_pkg::ALU_DIV;
        alu_req.a[41:0] = {dy[24], dy, 16'd0};
        alu_req.b       = 28'(l2);
      end
      S_ALIGN: begin
        alu_req.start   = (acnt != '0);
        alu_req.op      = bfsu_pkg::ALU_DIV;
        alu_req.a[41:0] = 42'(sumvx);
        alu_req.b       = 28'(acnt);
      end
      S_AL1: begin
        alu_req.start   = alu_rsp.done;
        alu_req.op      = bfsu_pkg::ALU_DIV;
        alu_req.a[41:0] = 42'(sumvy);
        alu_req.b       = 28'(acnt);
      end
      S_SEPD: begin
        alu_req.start   = (scnt != '0);
        alu_req.op      = bfsu_pkg::ALU_DIV;
        alu_req.a[41:0] = 42'(sepx);
        alu_req.b       = 28'(scnt);
      end
      S_SE1: begin
        alu_req.start   = alu_rsp.done;
        alu_req.op      = bfsu_pkg::ALU_DIV;
        alu_req.a[41:0] = 42'(sepy);
        alu_req.b       = 28'(scnt);
      end
      S_INT: begin
        alu_req.start   = 1'b1;
        alu_req.a[27:0] = 28'(ax);
        alu_req.b       = 28'(rq.time_step);
      end
      S_I1: begin
        alu_req.start   = alu_rsp.done;
        alu_req.a[27:0] = 28'(ay);
        alu_req.b       = 28'(rq.time_step);
      end
      S_I2: begin
        alu_req.start   = alu_rsp.done;
        alu_req.a[27:0] = 28'(ovx);
        alu_req.b       = 28'(rq.time_step);
      end
      S_I3: begin
        alu_req.start   = alu_rsp.done;
        alu_req.a[27:0] = 28'(ovy);
        alu_req.b       = 28'(rq.time_step);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (st)
      S_I1:    int_base = ovx;
      S_I2:    int_base = ovy;
      S_I3:    int_base = opx;
      default: int_base = opy;
    endcase
    int_sum = sat24(42'(int_base) + 42'(trunc16(prod)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= S_IDLE;
      live       <= '0;
      add_count  <= '0;
      max_spawns <= bfsu_pkg::SPAWN_RESET;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (req_valid) begin
            rq <= req_data;
            r  <= '0;
            w  <= '0;
            i  <= '0;
            found <= 1'b0;
            case (req_data.req_type)
              bfsu_pkg::REQ_ADD:    st <= S_ADD;
              bfsu_pkg::REQ_REMOVE: st <= S_RM_RD;
              bfsu_pkg::REQ_TICK:   st <= (live == '0) ? S_IDLE : S_OWN;
              default:              st <= S_IDLE;
            endcase
          end
        end
        S_ADD: begin
          pend <= '{out_id: rq.boid_id,
                    out_pos_x: add_ok ? rq.start_x : 24'sd0,
                    out_pos_y: add_ok ? rq.start_y : 24'sd0,
                    out_vel_x: 24'sd0, out_vel_y: 24'sd0,
                    accepted: add_ok, last: 1'b1};
          if (add_ok) begin
            live      <= live + 1'b1;
            add_count <= add_count + 10'd1;
          end
          emit_next <= S_IDLE;
          st        <= S_EMIT;
        end
        S_RM_RD: begin
          if (r == live) begin
            live <= w;
            pend <= '{out_id: rq.boid_id, out_pos_x: 24'sd0, out_pos_y: 24'sd0,
                      out_vel_x: 24'sd0, out_vel_y: 24'sd0,
                      accepted: found, last: 1'b1};
            emit_next <= S_IDLE;
            st        <= S_EMIT;
          end else begin
            st <= S_RM_WR;
          end
        end
        S_RM_WR: begin
          if (rd_e.id == rq.boid_id) begin
            found <= 1'b1;
          end else begin
            w <= w + 1'b1;
          end
          r  <= r + 1'b1;
          st <= S_RM_RD;
        end
        S_OWN: st <= S_OWN2;
        S_OWN2: begin
          oid    <= rd_e.id;
          opx    <= rd_e.px;
          opy    <= rd_e.py;
          ovx    <= rd_e.vx;
          ovy    <= rd_e.vy;
          nsx    <= 25'(rq.target_x) - 25'(rd_e.px);
          nsy    <= 25'(rq.target_y) - 25'(rd_e.py);
          nsc    <= bfsu_pkg::SEEK_SCALE;
          ns_ret <= S_SEEK_DONE;
          st     <= S_NS0;
        end
        S_SEEK_DONE: begin
          ax    <= 27'(nx) - 27'(ovx);
          ay    <= 27'(ny) - 27'(ovy);
          j     <= '0;
          acnt  <= '0;
          scnt  <= '0;
          sumvx <= '0;
          sumvy <= '0;
          sepx  <= '0;
          sepy  <= '0;
          st    <= S_NB;
        end
        S_NB: begin
          if (j == live) begin
            st <= S_ALIGN;
          end else if (j == i) begin
            j <= j + 1'b1;
          end else begin
            st <= S_NB1;
          end
        end
        S_NB1: begin
          dx <= 25'(opx) - 25'(rd_e.px);
          dy <= 25'(opy) - 25'(rd_e.py);
          st <= S_NB2;
        end
        S_NB2: st <= S_NB3;
        S_NB3: begin
          if (alu_rsp.done) begin
            sq <= prod[49:0];
            st <= S_NB4;
          end
        end
        S_NB4: begin
          if (alu_rsp.done) begin
            if (sum_sq < bfsu_pkg::RADIUS_SQ) begin
              acnt  <= acnt + 1'b1;
              sumvx <= sumvx + SUMV_W'(rd_e.vx);
              sumvy <= sumvy + SUMV_W'(rd_e.vy);
              st    <= S_NB5;
            end else begin
              j  <= j + 1'b1;
              st <= S_NB;
            end
          end
        end
        S_NB5: begin
          if (alu_rsp.done) begin
            if (root == 25'd0) begin
              // coincident neighbour: aligned with but not pushed away from
              j  <= j + 1'b1;
              st <= S_NB;
            end else begin
              st <= S_NB6;
            end
          end
        end
        S_NB6: begin
          if (alu_rsp.done) begin
            l2 <= prod[26:0];
            st <= S_NB7;
          end
        end
        S_NB7: begin
          if (alu_rsp.done) begin
            sepx <= sepx + SEP_W'(q);
            st   <= S_NB8;
          end
        end
        S_NB8: begin
          if (alu_rsp.done) begin
            sepy <= sepy + SEP_W'(q);
            scnt <= scnt + 1'b1;
            j    <= j + 1'b1;
            st   <= S_NB;
          end
        end
        S_ALIGN: st <= (acnt != '0) ? S_AL1 : S_SEPD;
        S_AL1: begin
          if (alu_rsp.done) begin
            nsx <= 25'(q);
            st  <= S_AL2;
          end
        end
        S_AL2: begin
          if (alu_rsp.done) begin
            nsy    <= 25'(q);
            nsc    <= bfsu_pkg::ALIGN_SCALE;
            ns_ret <= S_AL3;
            st     <= S_NS0;
          end
        end
        S_AL3: begin
          ax <= ax + 27'(nx) - 27'(ovx);
          ay <= ay + 27'(ny) - 27'(ovy);
          st <= S_SEPD;
        end
        S_SEPD: st <= (scnt != '0) ? S_SE1 : S_SEPC;
        S_SE1: begin
          if (alu_rsp.done) begin
            sepx <= SEP_W'(q);
            st   <= S_SE2;
          end
        end
        S_SE2: begin
          if (alu_rsp.done) begin
            sepy <= SEP_W'(q);
            st   <= S_SEPC;
          end
        end
        S_SEPC: begin
          if ((sepx != '0) || (sepy != '0)) begin
            nsx    <= 25'(sepx);
            nsy    <= 25'(sepy);
            nsc    <= bfsu_pkg::SEP_SCALE;
            ns_ret <= S_SE3;
            st     <= S_NS0;
          end else begin
            st <= S_INT;
          end
        end
        S_SE3: begin
          ax <= ax + 27'(nx) - 27'(ovx);
          ay <= ay + 27'(ny) - 27'(ovy);
          st <= S_INT;
        end
        S_INT: st <= S_I1;
        S_I1: begin
          if (alu_rsp.done) begin
            ovx <= int_sum;
            st  <= S_I2;
          end
        end
        S_I2: begin
          if (alu_rsp.done) begin
            ovy <= int_sum;
            st  <= S_I3;
          end
        end
        S_I3: begin
          if (alu_rsp.done) begin
            opx <= int_sum;
            st  <= S_I4;
          end
        end
        S_I4: begin
          if (alu_rsp.done) begin
            opy <= int_sum;
            st  <= S_WB;
          end
        end
        S_WB: begin
          pend <= '{out_id: oid, out_pos_x: opx, out_pos_y: opy,
                    out_vel_x: ovx, out_vel_y: ovy, accepted: 1'b0,
                    last: (CW'(i + 1'b1) == live)};
          emit_next <= (CW'(i + 1'b1) == live) ? S_IDLE : S_OWN;
          i         <= i + 1'b1;
          st        <= S_EMIT;
        end
        S_EMIT: begin
          if (rsp_free) begin
            rsp_valid <= 1'b1;
            rsp_data  <= pend;
            st        <= emit_next;
          end
        end
        // normalise (nsx, nsy) to length nsc; zero length gives zero
        S_NS0: st <= S_NS1;
        S_NS1: begin
          if (alu_rsp.done) begin
            sq <= prod[49:0];
            st <= S_NS2;
          end
        end
        S_NS2: begin
          if (alu_rsp.done) begin
            st <= S_NS3;
          end
        end
        S_NS3: begin
          if (alu_rsp.done) begin
            len <= root;
            if (root == 25'd0) begin
              nx <= '0;
              ny <= '0;
              st <= ns_ret;
            end else begin
              st <= S_NS4;
            end
          end
        end
        S_NS4: begin
          if (alu_rsp.done) begin
            st <= S_NS5;
          end
        end
        S_NS5: begin
          if (alu_rsp.done) begin
            nx <= 18'(q);
            st <= S_NS6;
          end
        end
        S_NS6: begin
          if (alu_rsp.done) begin
            st <= S_NS7;
          end
        end
        S_NS7: begin
          if (alu_rsp.done) begin
            ny <= 18'(q);
            st <= ns_ret;
          end
        end
        default: st <= S_IDLE;
      endcase
      if (cfg_write) begin
        max_spawns <= cfg_data;
        add_count  <= '0;
      end
    end
  end

`ifndef SYNTH
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live <= CW'(MAX_BOIDS))
    else $error("boid count above table depth");

  a_spawn_bound: assert property (@(posedge clk) disable iff (rst)
    add_count <= max_spawns)
    else $error("add count above spawn limit");

  a_alu_idle: assert property (@(posedge clk) disable iff (rst)
    (st == S_IDLE) |-> !alu_req.start)
    else $error("ALU started while idle");

  a_accept_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.accepted) |-> rsp_data.last)
    else $error("accepted result not marked last");
`endif

endmodule
